// ===== hw/rtl/lzsd_pkg.sv =====
`default_nettype none

package lzsd_pkg;

    localparam int OFFSET_BITS_DEF = 10;
    localparam int LENGTH_BITS_DEF = 6;
    localparam int MIN_MATCH_DEF   = 2;
    localparam int STORE_DEPTH_DEF = 2048;

    localparam int GROUP_ITEMS = 8;

    typedef struct packed {
        logic        lit;
        logic        tok;
        logic [7:0]  data;
        logic [15:0] token;
    } t_item;

    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      count;
        logic            last;
        logic            err;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/lzsd_ram.sv =====
`default_nettype none

module lzsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/lzsd_parse.sv =====
`default_nettype none

module lzsd_parse (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic [7:0]   i_data_byte,
    output lzsd_pkg::t_item   o_item
);

    logic [3:0] r_pos, n_pos;
    logic [7:0] r_flags, n_flags;
    logic       r_half, n_half;
    logic [7:0] r_low, n_low;
    logic       flag_bit;

    assign flag_bit = r_flags[3'd7 - r_pos[2:0]];

    always_comb begin
        n_pos        = r_pos;
        n_flags      = r_flags;
        n_half       = r_half;
        n_low        = r_low;
        o_item.lit   = 1'b0;
        o_item.tok   = 1'b0;
        o_item.data  = i_data_byte;
        o_item.token = {i_data_byte, r_low};
        if (i_accept) begin
            priority if (r_pos >= 4'(lzsd_pkg::GROUP_ITEMS)) begin
                n_flags = i_data_byte;
                n_pos   = 4'd0;
                n_half  = 1'b0;
            end else if (!flag_bit) begin
                o_item.lit = 1'b1;
                n_pos      = r_pos + 4'd1;
            end else if (!r_half) begin
                n_low  = i_data_byte;
                n_half = 1'b1;
            end else begin
                o_item.tok = 1'b1;
                n_half     = 1'b0;
                n_pos      = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 4'(lzsd_pkg::GROUP_ITEMS);
            r_flags <= 8'd0;
            r_half  <= 1'b0;
            r_low   <= 8'd0;
        end else begin
            r_pos   <= n_pos;
            r_flags <= n_flags;
            r_half  <= n_half;
            r_low   <= n_low;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lzsd_core.sv =====
`default_nettype none

module lzsd_core #(
    parameter int OFFSET_BITS = lzsd_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = lzsd_pkg::LENGTH_BITS_DEF,
    parameter int MIN_MATCH   = lzsd_pkg::MIN_MATCH_DEF,
    parameter int STORE_DEPTH = lzsd_pkg::STORE_DEPTH_DEF,
    localparam int AW         = $clog2(STORE_DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lzsd_pkg::t_item i_item,
    input  wire logic          i_out_stall,
    output logic               o_hold,
    output logic               o_result_vld,
    output lzsd_pkg::t_result  o_result,
    output logic               o_ram_wr_en,
    output logic [AW-1:0]      o_ram_wr_addr,
    output logic [7:0]         o_ram_wr_data,
    output logic               o_ram_rd_en,
    output logic [AW-1:0]      o_ram_rd_addr,
    input  wire logic [7:0]    i_ram_rd_data
);

    localparam int WINDOW = (1 << OFFSET_BITS) - 1 + MIN_MATCH;
    localparam int MAXC   = (1 << LENGTH_BITS) - 1 + MIN_MATCH;
    localparam int FMAX   = (WINDOW > MAXC) ? WINDOW : MAXC;
    localparam int FW     = $clog2(FMAX + 1);
    localparam int LW     = $clog2(MAXC + 1);
    localparam int M1     = (FW > OFFSET_BITS) ? FW : OFFSET_BITS;
    localparam int M2     = (M1 > LW) ? M1 : LW;
    localparam int M3     = (M2 > AW) ? M2 : AW;
    localparam int XW     = M3 + 2;

    function automatic logic [AW-1:0] f_wrap(input logic [XW-1:0] s);
        f_wrap = (s >= XW'(STORE_DEPTH)) ? AW'(s - XW'(STORE_DEPTH)) : AW'(s);
    endfunction

    logic [FW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_oldest, n_oldest;
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic              r_busy, n_busy;
    logic              r_rd_vld, n_rd_vld;
    logic              r_err, n_err;
    logic [LW-1:0]     r_issue_left, n_issue_left;
    logic [LW-1:0]     r_cons_left, n_cons_left;
    logic [1:0]        r_lane, n_lane;
    logic [2:0][7:0]   r_pack, n_pack;
    logic              r_out_vld, n_out_vld;
    lzsd_pkg::t_result r_res, n_res;

    logic [15:0]          tok_sh;
    logic [OFFSET_BITS-1:0] tok_start;
    logic [LW-1:0]        item_len;
    logic                 item_vld;
    logic                 tok_err;
    logic [XW-1:0]        fill_sum;
    logic [XW-1:0]        fill_new;
    logic [XW-1:0]        drop;
    logic                 out_free;
    logic                 finalize;
    logic                 consume;
    logic                 issue;
    logic [7:0]           cbyte;

    assign item_vld  = i_item.lit | i_item.tok;
    assign tok_sh    = i_item.token >> LENGTH_BITS;
    assign tok_start = tok_sh[OFFSET_BITS-1:0];
    assign item_len  = i_item.lit ? LW'(1)
                     : LW'(i_item.token[LENGTH_BITS-1:0]) + LW'(MIN_MATCH);
    assign tok_err   = (XW'(tok_start) + XW'(item_len)) > XW'(r_fill);
    assign fill_sum  = XW'(r_fill) + XW'(item_len);
    assign fill_new  = (fill_sum > XW'(WINDOW))
                     ? ((XW'(item_len) > XW'(WINDOW)) ? XW'(item_len) : XW'(WINDOW))
                     : fill_sum;
    assign drop      = fill_sum - fill_new;

    assign out_free  = !r_out_vld || !i_out_stall;
    assign finalize  = r_rd_vld && ((r_lane == 2'd3) || (r_cons_left == LW'(1)));
    assign consume   = r_rd_vld && (!finalize || out_free);
    assign issue     = r_busy && (r_issue_left != '0) && (!r_rd_vld || consume);
    assign cbyte     = r_err ? 8'd0 : i_ram_rd_data;

    always_comb begin
        n_fill       = r_fill;
        n_oldest     = r_oldest;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_busy       = r_busy;
        n_err        = r_err;
        n_issue_left = r_issue_left;
        n_cons_left  = r_cons_left;
        n_lane       = r_lane;
        n_pack       = r_pack;
        n_res        = r_res;
        n_out_vld    = r_out_vld && i_out_stall;
        n_rd_vld     = issue || (r_rd_vld && !consume);

        o_ram_wr_en   = 1'b0;
        o_ram_wr_addr = r_wr_ptr;
        o_ram_wr_data = cbyte;
        o_ram_rd_en   = issue;
        o_ram_rd_addr = r_rd_ptr;

        if (item_vld) begin
            n_fill   = FW'(fill_new);
            n_oldest = f_wrap(XW'(r_oldest) + drop);
            if (i_item.lit) begin
                o_ram_wr_en   = 1'b1;
                o_ram_wr_data = i_item.data;
                n_wr_ptr      = f_wrap(XW'(r_wr_ptr) + XW'(1));
                n_out_vld     = 1'b1;
                n_res.data    = {24'd0, i_item.data};
                n_res.count   = 3'd1;
                n_res.last    = 1'b1;
                n_res.err     = 1'b0;
            end else begin
                n_busy       = 1'b1;
                n_err        = tok_err;
                n_rd_ptr     = f_wrap(XW'(r_oldest) + XW'(tok_start));
                n_issue_left = item_len;
                n_cons_left  = item_len;
                n_lane       = 2'd0;
            end
        end

        if (issue) begin
            n_rd_ptr     = f_wrap(XW'(r_rd_ptr) + XW'(1));
            n_issue_left = r_issue_left - LW'(1);
        end

        if (consume) begin
            o_ram_wr_en = 1'b1;
            n_wr_ptr    = f_wrap(XW'(r_wr_ptr) + XW'(1));
            n_cons_left = r_cons_left - LW'(1);
            if (finalize) begin
                for (int j = 0; j < 3; j++) begin
                    if (2'(j) < r_lane) begin
                        n_res.data[j] = r_pack[j];
                    end else if (2'(j) == r_lane) begin
                        n_res.data[j] = cbyte;
                    end else begin
                        n_res.data[j] = 8'd0;
                    end
                end
                n_res.data[3] = (r_lane == 2'd3) ? cbyte : 8'd0;
                n_res.count = 3'(r_lane) + 3'd1;
                n_res.last  = (r_cons_left == LW'(1));
                n_res.err   = r_err;
                n_out_vld   = 1'b1;
                n_lane      = 2'd0;
                if (r_cons_left == LW'(1)) begin
                    n_busy = 1'b0;
                end
            end else begin
                n_pack[r_lane] = cbyte;
                n_lane         = r_lane + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_oldest     <= '0;
            r_wr_ptr     <= '0;
            r_busy       <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_issue_left <= '0;
            r_cons_left  <= '0;
            r_lane       <= 2'd0;
            r_out_vld    <= 1'b0;
        end else begin
            r_fill       <= n_fill;
            r_oldest     <= n_oldest;
            r_wr_ptr     <= n_wr_ptr;
            r_busy       <= n_busy;
            r_rd_vld     <= n_rd_vld;
            r_issue_left <= n_issue_left;
            r_cons_left  <= n_cons_left;
            r_lane       <= n_lane;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_err    <= n_err;
        r_pack   <= n_pack;
        r_res    <= n_res;
    end

    assign o_hold       = r_busy || (r_out_vld && i_out_stall);
    assign o_result_vld = r_out_vld;
    assign o_result     = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/lzss_stream_decoder.sv =====
// Channel  Direction  Handshake                Payload
// input    in         i_in_valid / o_in_stall  i_data_byte
// output   out        o_out_valid / i_out_stall o_out_byte0..3, o_byte_count,
//                                               o_last_of_item, o_range_error
//
// Flag bytes, literals and the first byte of a token do not by themselves hold the input.
// A token holds the input until its copy bytes are read back: the history RAM
// has one read port and a registered read, one byte read per cycle unless the
// output stalls; a full, stalled output register also holds the input.
// Reset is synchronous; the history RAM needs no clearing pass.
`default_nettype none

module lzss_stream_decoder #(
    parameter int OFFSET_BITS = lzsd_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = lzsd_pkg::LENGTH_BITS_DEF,
    parameter int MIN_MATCH   = lzsd_pkg::MIN_MATCH_DEF,
    parameter int STORE_DEPTH = lzsd_pkg::STORE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte0,
    output logic [7:0]      o_out_byte1,
    output logic [7:0]      o_out_byte2,
    output logic [7:0]      o_out_byte3,
    output logic [2:0]      o_byte_count,
    output logic            o_last_of_item,
    output logic            o_range_error
);

    localparam int AW = $clog2(STORE_DEPTH);

    lzsd_pkg::t_item   item;
    lzsd_pkg::t_result res;
    logic              accept;
    logic              hold;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;

    assign accept     = i_in_valid && !hold;
    assign o_in_stall = hold;

    lzsd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_item      (item)
    );

    lzsd_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .MIN_MATCH   (MIN_MATCH),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item),
        .i_out_stall   (i_out_stall),
        .o_hold        (hold),
        .o_result_vld  (o_out_valid),
        .o_result      (res),
        .o_ram_wr_en   (wr_en),
        .o_ram_wr_addr (wr_addr),
        .o_ram_wr_data (wr_data),
        .o_ram_rd_en   (rd_en),
        .o_ram_rd_addr (rd_addr),
        .i_ram_rd_data (rd_data)
    );

    lzsd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_byte0    = res.data[0];
    assign o_out_byte1    = res.data[1];
    assign o_out_byte2    = res.data[2];
    assign o_out_byte3    = res.data[3];
    assign o_byte_count   = res.count;
    assign o_last_of_item = res.last;
    assign o_range_error  = res.err;

endmodule

`default_nettype wire

// ===== tb/lzss_stream_decoder_checker.sv =====
`default_nettype none

module lzss_stream_decoder_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [7:0] i_out_byte0,
    input  wire logic [7:0] i_out_byte1,
    input  wire logic [7:0] i_out_byte2,
    input  wire logic [7:0] i_out_byte3,
    input  wire logic [2:0] i_byte_count,
    input  wire logic       i_last_of_item,
    input  wire logic       i_range_error,
    output int              o_words_waiting,
    output int              o_mismatches
);

    localparam int OFFSET_BITS  = lzsd_pkg::OFFSET_BITS_DEF;
    localparam int LENGTH_BITS  = lzsd_pkg::LENGTH_BITS_DEF;
    localparam int MIN_MATCH    = lzsd_pkg::MIN_MATCH_DEF;
    localparam int STORE_DEPTH  = lzsd_pkg::STORE_DEPTH_DEF;
    localparam int GROUP_ITEMS  = lzsd_pkg::GROUP_ITEMS;
    localparam int WINDOW_BYTES = (1 << OFFSET_BITS) - 1 + MIN_MATCH;
    localparam int MAX_RUN      = (1 << LENGTH_BITS) - 1 + MIN_MATCH;

    logic [7:0]  window_ram [STORE_DEPTH];
    int unsigned window_head;
    int unsigned window_fill;
    logic [7:0]  flag_bits;
    int unsigned item_slot;
    logic        low_held;
    logic [7:0]  held_low;

    lzsd_pkg::t_result pending_words [$];
    int                mismatches;

    assign o_mismatches = mismatches;

    task automatic decode_stream_byte(input logic [7:0] b);
        logic [7:0]        run_bytes [MAX_RUN];
        int unsigned       run_len;
        int unsigned       start;
        int unsigned       token;
        int unsigned       drop;
        int unsigned       done;
        int unsigned       n;
        logic              run_err;
        lzsd_pkg::t_result word;
        run_err = 1'b0;
        if (item_slot >= GROUP_ITEMS) begin
            flag_bits = b;
            item_slot = 0;
            low_held  = 1'b0;
            return;
        end
        if (!flag_bits[GROUP_ITEMS - 1 - item_slot]) begin
            run_bytes[0] = b;
            run_len      = 1;
        end else if (!low_held) begin
            held_low = b;
            low_held = 1'b1;
            return;
        end else begin
            low_held = 1'b0;
            token    = {b, held_low};
            start    = (token >> LENGTH_BITS) & ((1 << OFFSET_BITS) - 1);
            run_len  = (token & ((1 << LENGTH_BITS) - 1)) + MIN_MATCH;
            run_err  = (start + run_len > window_fill);
            for (int k = 0; k < run_len; k++) begin
                run_bytes[k] = run_err ? 8'h00 :
                    window_ram[(window_head + start + k) % STORE_DEPTH];
            end
        end
        item_slot++;
        done = 0;
        while (done < run_len) begin
            n    = (run_len - done > 4) ? 4 : run_len - done;
            word = '0;
            for (int j = 0; j < n; j++) begin
                word.data[j] = run_bytes[done + j];
            end
            word.count = 3'(n);
            done      += n;
            word.last  = (done >= run_len);
            word.err   = run_err;
            pending_words.push_back(word);
        end
        // drop the oldest bytes before appending the run
        if (window_fill + run_len > WINDOW_BYTES) begin
            drop = window_fill + run_len - WINDOW_BYTES;
            if (drop > window_fill) begin
                drop = window_fill;
            end
            window_head  = (window_head + drop) % STORE_DEPTH;
            window_fill -= drop;
        end
        for (int k = 0; k < run_len; k++) begin
            window_ram[(window_head + window_fill + k) % STORE_DEPTH] = run_bytes[k];
        end
        window_fill += run_len;
    endtask

    task automatic check_word();
        lzsd_pkg::t_result want;
        logic [7:0]        got [4];
        if (pending_words.size() == 0) begin
            $error("unexpected result word: byte_count %0d, out_byte0 0x%02h",
                   i_byte_count, i_out_byte0);
            mismatches++;
            return;
        end
        want = pending_words.pop_front();
        got  = '{i_out_byte0, i_out_byte1, i_out_byte2, i_out_byte3};
        for (int j = 0; j < 4; j++) begin
            if (got[j] !== want.data[j]) begin
                $error("out_byte%0d: expected 0x%02h, actual 0x%02h",
                       j, want.data[j], got[j]);
                mismatches++;
            end
        end
        if (i_byte_count !== want.count) begin
            $error("byte_count: expected %0d, actual %0d", want.count, i_byte_count);
            mismatches++;
        end
        if (i_last_of_item !== want.last) begin
            $error("last_of_item: expected %0b, actual %0b", want.last, i_last_of_item);
            mismatches++;
        end
        if (i_range_error !== want.err) begin
            $error("range_error: expected %0b, actual %0b", want.err, i_range_error);
            mismatches++;
        end
    endtask

    initial begin
        mismatches = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                window_ram[k] = 8'h00;
            end
            window_head = 0;
            window_fill = 0;
            flag_bits   = 8'h00;
            item_slot   = GROUP_ITEMS;
            low_held    = 1'b0;
            held_low    = 8'h00;
            pending_words.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                decode_stream_byte(i_data_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                check_word();
            end
        end
        o_words_waiting <= pending_words.size();
    end

endmodule

`default_nettype wire

// ===== tb/lzss_stream_decoder_tb.sv =====
`default_nettype none

module lzss_stream_decoder_tb;

    localparam int LEN_BITS     = lzsd_pkg::LENGTH_BITS_DEF;
    localparam int MIN_RUN      = lzsd_pkg::MIN_MATCH_DEF;
    localparam int OFFSET_MAX   = (1 << lzsd_pkg::OFFSET_BITS_DEF) - 1;
    localparam int WINDOW_BYTES = OFFSET_MAX + MIN_RUN;
    localparam int MAX_RUN      = (1 << LEN_BITS) - 1 + MIN_RUN;
    localparam int PHASE_BYTES  = 70;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 100;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_out_stall = 1'b0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte0;
    logic [7:0] o_out_byte1;
    logic [7:0] o_out_byte2;
    logic [7:0] o_out_byte3;
    logic [2:0] o_byte_count;
    logic       o_last_of_item;
    logic       o_range_error;

    int words_waiting;
    int mismatches;
    int send_gap_pct   = 13;
    int recv_stall_pct = 50;
    int bytes_sent     = 0;
    int known_fill     = 0;
    int cycle_count    = 0;

    lzss_stream_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte0   (o_out_byte0),
        .o_out_byte1   (o_out_byte1),
        .o_out_byte2   (o_out_byte2),
        .o_out_byte3   (o_out_byte3),
        .o_byte_count  (o_byte_count),
        .o_last_of_item(o_last_of_item),
        .o_range_error (o_range_error)
    );

    lzss_stream_decoder_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_byte0    (o_out_byte0),
        .i_out_byte1    (o_out_byte1),
        .i_out_byte2    (o_out_byte2),
        .i_out_byte3    (o_out_byte3),
        .i_byte_count   (o_byte_count),
        .i_last_of_item (o_last_of_item),
        .i_range_error  (o_range_error),
        .o_words_waiting(words_waiting),
        .o_mismatches   (mismatches)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lzss_stream_decoder verification failed");
            $finish;
        end
    end

    // hold valid high between back-to-back transactions
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    task automatic note_window(input int run_len);
        known_fill = (known_fill + run_len > WINDOW_BYTES) ? WINDOW_BYTES
                                                            : known_fill + run_len;
    endtask

    task automatic send_literal(input logic [7:0] b);
        push_byte(b);
        note_window(1);
    endtask

    task automatic send_raw_token(input logic [15:0] token);
        push_byte(token[7:0]);
        push_byte(token[15:8]);
        note_window(int'(token[LEN_BITS-1:0]) + MIN_RUN);
    endtask

    task automatic send_copy(input int start, input int run_len);
        send_raw_token(16'((start << LEN_BITS) | (run_len - MIN_RUN)));
    endtask

    task automatic random_copy();
        int pick;
        int run_len;
        int start;
        pick    = $urandom_range(99);
        run_len = ($urandom_range(3) == 0) ? $urandom_range(MAX_RUN, MIN_RUN)
                                           : $urandom_range(9, MIN_RUN);
        if (pick < 10) begin
            send_raw_token(16'($urandom));
        end else begin
            if (known_fill < run_len) begin
                start = $urandom_range(OFFSET_MAX, 0);
            end else if (pick < 18 && known_fill - run_len + 1 <= OFFSET_MAX) begin
                start = known_fill - run_len + 1;
            end else if (pick < 50) begin
                start = known_fill - run_len;
            end else begin
                start = $urandom_range(known_fill - run_len, 0);
            end
            send_copy(start, run_len);
        end
    endtask

    task automatic random_group();
        logic [7:0] flags;
        flags = 8'($urandom);
        push_byte(flags);
        for (int i = 7; i >= 0; i--) begin
            if (flags[i]) begin
                random_copy();
            end else begin
                send_literal(8'($urandom));
            end
        end
    endtask

    task automatic wait_all_words();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_waiting != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic random_phase(input int gap_pct, input int stall_pct);
        int target;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        target         = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target) begin
            random_group();
        end
        wait_all_words();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_byte(8'h00);
        send_literal(8'h00);
        send_literal(8'hFF);
        send_literal(8'h55);
        send_literal(8'hAA);
        send_literal(8'h01);
        send_literal(8'h80);
        send_literal(8'h7F);
        send_literal(8'hFE);
        push_byte(8'hFF);
        send_copy(0, MIN_RUN);
        send_copy(2, 8);
        send_raw_token(16'hFFFF);
        send_copy(0, MAX_RUN);
        send_copy(known_fill - 7, 7);
        send_copy(known_fill - 1, 2);
        send_copy(known_fill - 5, 6);
        send_copy(3, 4);
        wait_all_words();

        random_phase(13, 50);
        random_phase(50, 13);
        random_phase(0, 0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("lzss_stream_decoder verification clean");
        end else begin
            $display("lzss_stream_decoder verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
